// ===== rtl/wpmc_pkg.sv =====
// ----------------------------------------------------------------------------
// wpmc_pkg
// Shared types and constants for the watering pump mode controller.
// ----------------------------------------------------------------------------
package wpmc_pkg;

    // Configuration register widths and indexes
    localparam int MOIST_W    = 10;
    localparam int SECONDS_W  = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_RUN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_RUN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_EVERY = 3'd4;

    // Register reset values
    localparam logic [MOIST_W-1:0]   LOW_LIMIT_RST    = 10'd300;
    localparam logic [MOIST_W-1:0]   HIGH_LIMIT_RST   = 10'd700;
    localparam logic [SECONDS_W-1:0] AUTO_RUN_RST     = 12'd60;
    localparam logic [SECONDS_W-1:0] MANUAL_RUN_RST   = 12'd10;
    localparam logic [SECONDS_W-1:0] SAMPLE_EVERY_RST = 12'd5;

    // LED codes
    localparam logic [1:0] LED_IDLE  = 2'd0;
    localparam logic [1:0] LED_PUMP  = 2'd1;
    localparam logic [1:0] LED_ALERT = 2'd2;

    // One tick request
    typedef struct packed {
        logic               mode_press;
        logic               manual_press;
        logic [MOIST_W-1:0] moisture_sample;
    } t_in_item;

    // One tick result
    typedef struct packed {
        logic       pump_drive;
        logic [1:0] led_code;
        logic       manual_active;
        logic       sample_latched;
    } t_out_item;

    // Current configuration
    typedef struct packed {
        logic [MOIST_W-1:0]   low_moisture_limit;
        logic [MOIST_W-1:0]   high_moisture_limit;
        logic [SECONDS_W-1:0] auto_run_seconds;
        logic [SECONDS_W-1:0] manual_run_seconds;
        logic [SECONDS_W-1:0] sample_every_seconds;
    } t_cfg;

endpackage

// ===== rtl/wpmc_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// wpmc_cfg_regs
// Configuration register file with a plain write port and reset defaults.
// ----------------------------------------------------------------------------
module wpmc_cfg_regs (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [wpmc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wpmc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output wpmc_pkg::t_cfg                     o_cfg
);
    import wpmc_pkg::*;

    t_cfg r_cfg;

    // Decode the index and write the selected register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.low_moisture_limit   <= LOW_LIMIT_RST;
            r_cfg.high_moisture_limit  <= HIGH_LIMIT_RST;
            r_cfg.auto_run_seconds     <= AUTO_RUN_RST;
            r_cfg.manual_run_seconds   <= MANUAL_RUN_RST;
            r_cfg.sample_every_seconds <= SAMPLE_EVERY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOW_LIMIT:    r_cfg.low_moisture_limit   <= i_cfg_data[MOIST_W-1:0];
                CFG_HIGH_LIMIT:   r_cfg.high_moisture_limit  <= i_cfg_data[MOIST_W-1:0];
                CFG_AUTO_RUN:     r_cfg.auto_run_seconds     <= i_cfg_data[SECONDS_W-1:0];
                CFG_MANUAL_RUN:   r_cfg.manual_run_seconds   <= i_cfg_data[SECONDS_W-1:0];
                CFG_SAMPLE_EVERY: r_cfg.sample_every_seconds <= i_cfg_data[SECONDS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/wpmc_core.sv =====
// ----------------------------------------------------------------------------
// wpmc_core
// Controller state and the single-pass tick update: mode toggle, sample
// latch, then auto or manual pump logic.
// ----------------------------------------------------------------------------
module wpmc_core #(
    parameter int TICK_COUNT_BITS = 12
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  wpmc_pkg::t_in_item  i_item,
    input  wpmc_pkg::t_cfg      i_cfg,
    output wpmc_pkg::t_out_item o_result
);
    import wpmc_pkg::*;

    localparam int TW    = TICK_COUNT_BITS;
    localparam int CMP_W = (TICK_COUNT_BITS > SECONDS_W) ? TICK_COUNT_BITS : SECONDS_W;

    logic               r_manual;
    logic               r_pump;
    logic [1:0]         r_led;
    logic [TW-1:0]      r_run_ticks;
    logic [TW-1:0]      r_sample_ticks;
    logic [MOIST_W-1:0] r_held;

    logic               n_manual;
    logic               n_pump;
    logic [1:0]         n_led;
    logic [TW-1:0]      n_run_ticks;
    logic [TW-1:0]      n_sample_ticks;
    logic [MOIST_W-1:0] n_held;
    logic               n_latched;

    logic [TW-1:0]      sample_inc;
    logic               below_low;

    // Saturating tick increment
    function automatic logic [TW-1:0] tick_inc(input logic [TW-1:0] v);
        logic [TW-1:0] r;
        r = (v == {TW{1'b1}}) ? v : v + {{(TW-1){1'b0}}, 1'b1};
        return r;
    endfunction

    // Compare a tick count against a seconds limit at a common width
    function automatic logic reached(input logic [TW-1:0] cnt,
                                     input logic [SECONDS_W-1:0] lim);
        logic r;
        r = (CMP_W'(cnt) >= CMP_W'(lim));
        return r;
    endfunction

    // Work out the next state for the request in the input register
    always_comb begin
        n_manual       = r_manual ^ i_item.mode_press;
        n_pump         = r_pump;
        n_led          = r_led;
        n_run_ticks    = r_run_ticks;
        n_held         = r_held;
        n_latched      = 1'b0;
        sample_inc     = tick_inc(r_sample_ticks);
        n_sample_ticks = sample_inc;

        // Entering manual mode stops the pump
        if (i_item.mode_press && n_manual && n_pump) begin
            n_pump = 1'b0;
            n_led  = LED_IDLE;
        end

        // Latch a sample when the interval is reached
        if (reached(sample_inc, i_cfg.sample_every_seconds)) begin
            n_sample_ticks = '0;
            n_held         = i_item.moisture_sample;
            n_latched      = 1'b1;
        end

        below_low = (n_held < i_cfg.low_moisture_limit);

        if (!n_manual) begin
            // Auto mode: start dry, stop wet or on timeout
            if (below_low && !n_pump) begin
                n_pump      = 1'b1;
                n_led       = LED_PUMP;
                n_run_ticks = '0;
            end
            if (n_pump) begin
                n_run_ticks = tick_inc(n_run_ticks);
                if (n_held > i_cfg.high_moisture_limit) begin
                    n_pump = 1'b0;
                    n_led  = LED_IDLE;
                end else if (reached(n_run_ticks, i_cfg.auto_run_seconds)) begin
                    n_pump = 1'b0;
                    n_led  = LED_ALERT;
                end
            end
            if (!n_pump) begin
                n_led = below_low ? LED_ALERT : LED_IDLE;
            end
        end else begin
            // Manual mode: one timed run per press
            if (i_item.manual_press && !n_pump) begin
                n_pump      = 1'b1;
                n_led       = LED_PUMP;
                n_run_ticks = '0;
            end
            if (n_pump) begin
                n_run_ticks = tick_inc(n_run_ticks);
                if (reached(n_run_ticks, i_cfg.manual_run_seconds)) begin
                    n_pump = 1'b0;
                    n_led  = LED_IDLE;
                end
            end
        end
    end

    // Commit state when the request moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_manual       <= 1'b0;
            r_pump         <= 1'b0;
            r_led          <= LED_IDLE;
            r_run_ticks    <= '0;
            r_sample_ticks <= '0;
            r_held         <= '0;
        end else if (i_advance) begin
            r_manual       <= n_manual;
            r_pump         <= n_pump;
            r_led          <= n_led;
            r_run_ticks    <= n_run_ticks;
            r_sample_ticks <= n_sample_ticks;
            r_held         <= n_held;
        end
    end

    assign o_result.pump_drive     = n_pump;
    assign o_result.led_code       = n_led;
    assign o_result.manual_active  = n_manual;
    assign o_result.sample_latched = n_latched;

endmodule

// ===== rtl/watering_pump_mode_controller_unit.sv =====
// ----------------------------------------------------------------------------
// watering_pump_mode_controller_unit
// Top level: input register, tick update core and result register.
// ----------------------------------------------------------------------------
// Each request is one one-second tick with the mode button, the manual button
// and a moisture sample; each produces exactly one result with the pump drive,
// LED code, mode and a sample-latched flag. A request is held in the input
// register and its result is registered into the output register as it moves
// on; one request is taken every cycle while results are accepted, and the core
// does its state update in a single pass. Configuration writes take effect at
// the next edge; the user must make them while the block is idle, which it does
// not enforce. Run and sample counters are TICK_COUNT_BITS wide and saturate.
module watering_pump_mode_controller_unit #(
    parameter int TICK_COUNT_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  wpmc_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output wpmc_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [wpmc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wpmc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import wpmc_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in_data;
    logic      r_out_valid;
    t_out_item r_out_data;

    logic      advance;
    t_cfg      cfg;
    t_out_item result;

    // Move the held request on when the result register is free
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_data <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= result;
        end
    end

    wpmc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    wpmc_core #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_data),
        .i_cfg     (cfg),
        .o_result  (result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // A running pump always shows the watering LED
    a_pump_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_data.pump_drive) |-> (r_out_data.led_code == LED_PUMP))
        else $error("pump on without watering LED");

    // The LED code stays within its defined codes
    a_led_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_data.led_code != 2'd3))
        else $error("undefined LED code");

    // A request held behind a stalled result is not lost
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_out_ready) |=> (r_in_valid && $stable(r_in_data)))
        else $error("held request dropped");

    // A stalled result holds its value
    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("stalled result changed");

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the watering pump mode controller unit.
// ----------------------------------------------------------------------------
// Sends one-second tick requests and checks every result against a cycle-free
// model of the pump, LED, mode and sample logic that runs alongside. First a
// short directed run covers mode toggles, manual runs, leaving manual mode
// while pumping, moisture above full scale and zero intervals. Then random
// phases run under several register settings, with random gaps on both sides
// and one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wpmc_pkg::*;

    localparam int TICK_BITS       = 12;
    localparam int DRAIN_CYCLES    = 4;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int WATCHDOG_LIMIT  = 1000;

    // Model of the tick logic plus the queue of results it predicts
    class pump_state_tracker;
        t_cfg                 cfg;
        bit                   manual_mode;
        bit                   pump_on;
        logic [1:0]           led;
        logic [TICK_BITS-1:0] run_ticks;
        logic [TICK_BITS-1:0] sample_ticks;
        logic [MOIST_W-1:0]   held_moisture;
        t_out_item            pending_results[$];
        int                   fail_count;

        function new();
            cfg.low_moisture_limit   = LOW_LIMIT_RST;
            cfg.high_moisture_limit  = HIGH_LIMIT_RST;
            cfg.auto_run_seconds     = AUTO_RUN_RST;
            cfg.manual_run_seconds   = MANUAL_RUN_RST;
            cfg.sample_every_seconds = SAMPLE_EVERY_RST;
            manual_mode   = 1'b0;
            pump_on       = 1'b0;
            led           = LED_IDLE;
            run_ticks     = '0;
            sample_ticks  = '0;
            held_moisture = '0;
            fail_count    = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_LOW_LIMIT:    cfg.low_moisture_limit   = val[MOIST_W-1:0];
                CFG_HIGH_LIMIT:   cfg.high_moisture_limit  = val[MOIST_W-1:0];
                CFG_AUTO_RUN:     cfg.auto_run_seconds     = val[SECONDS_W-1:0];
                CFG_MANUAL_RUN:   cfg.manual_run_seconds   = val[SECONDS_W-1:0];
                CFG_SAMPLE_EVERY: cfg.sample_every_seconds = val[SECONDS_W-1:0];
                default: ;
            endcase
        endfunction

        // Saturating tick counter step
        function logic [TICK_BITS-1:0] bump(logic [TICK_BITS-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function void begin_run();
            pump_on   = 1'b1;
            led       = LED_PUMP;
            run_ticks = '0;
        endfunction

        // Advance the model by one accepted tick and queue its result
        function void note_tick(t_in_item item);
            t_out_item res;
            bit        latched;
            latched = 1'b0;

            // Toggle mode; entering manual drops a running pump
            if (item.mode_press) begin
                manual_mode = !manual_mode;
                if (manual_mode && pump_on) begin
                    pump_on = 1'b0;
                    led     = LED_IDLE;
                end
            end

            // Advance the sample interval and latch on expiry
            sample_ticks = bump(sample_ticks);
            if (sample_ticks >= cfg.sample_every_seconds) begin
                sample_ticks  = '0;
                held_moisture = item.moisture_sample;
                latched       = 1'b1;
            end

            if (!manual_mode) begin
                if (held_moisture < cfg.low_moisture_limit && !pump_on)
                    begin_run();
                if (pump_on) begin
                    run_ticks = bump(run_ticks);
                    if (held_moisture > cfg.high_moisture_limit) begin
                        pump_on = 1'b0;
                        led     = LED_IDLE;
                    end else if (run_ticks >= cfg.auto_run_seconds) begin
                        pump_on = 1'b0;
                        led     = LED_ALERT;
                    end
                end
                if (!pump_on)
                    led = (held_moisture < cfg.low_moisture_limit) ? LED_ALERT : LED_IDLE;
            end else begin
                if (item.manual_press && !pump_on)
                    begin_run();
                if (pump_on) begin
                    run_ticks = bump(run_ticks);
                    if (run_ticks >= cfg.manual_run_seconds) begin
                        pump_on = 1'b0;
                        led     = LED_IDLE;
                    end
                end
            end

            res.pump_drive     = pump_on;
            res.led_code       = led;
            res.manual_active  = manual_mode;
            res.sample_latched = latched;
            pending_results.push_back(res);
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(t_out_item got);
            t_out_item exp;
            if (pending_results.size() == 0) begin
                $error("result with no tick outstanding: %h", got);
                fail_count++;
                return;
            end
            exp = pending_results.pop_front();
            if (got.pump_drive !== exp.pump_drive) begin
                $error("pump_drive: expected %0d, actual %0d", exp.pump_drive, got.pump_drive);
                fail_count++;
            end
            if (got.led_code !== exp.led_code) begin
                $error("led_code: expected %0d, actual %0d", exp.led_code, got.led_code);
                fail_count++;
            end
            if (got.manual_active !== exp.manual_active) begin
                $error("manual_active: expected %0d, actual %0d",
                       exp.manual_active, got.manual_active);
                fail_count++;
            end
            if (got.sample_latched !== exp.sample_latched) begin
                $error("sample_latched: expected %0d, actual %0d",
                       exp.sample_latched, got.sample_latched);
                fail_count++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    pump_state_tracker tracker;
    bit                send_gaps_on = 1'b0;
    bit                recv_stalls_on = 1'b0;
    bit                hold_off_req = 1'b0;
    int                stall_left = 0;
    int                quiet_cycles = 0;

    watering_pump_mode_controller_unit #(
        .TICK_COUNT_BITS(TICK_BITS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: check accepted results, then draw the next stall
    always @(posedge i_clk) begin
        if (i_out_ready && o_out_valid) begin
            tracker.check_result(o_out_data);
            stall_left = recv_stalls_on ? $urandom_range(0, 14) : 0;
        end
        if (hold_off_req) begin
            stall_left   = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
        end
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    function automatic t_in_item make_tick(bit mode, bit manual, int moisture);
        t_in_item it;
        it.mode_press      = mode;
        it.manual_press    = manual;
        it.moisture_sample = moisture[MOIST_W-1:0];
        return it;
    endfunction

    function automatic t_cfg make_cfg(int low, int high, int auto_s, int manual_s, int every);
        t_cfg c;
        c.low_moisture_limit   = low[MOIST_W-1:0];
        c.high_moisture_limit  = high[MOIST_W-1:0];
        c.auto_run_seconds     = auto_s[SECONDS_W-1:0];
        c.manual_run_seconds   = manual_s[SECONDS_W-1:0];
        c.sample_every_seconds = every[SECONDS_W-1:0];
        return c;
    endfunction

    // Random tick: rare mode presses, frequent manual presses, some overrange
    function automatic t_in_item random_tick();
        int moisture;
        moisture = ($urandom_range(0, 15) == 0) ? $urandom_range(1001, 1023)
                                                : $urandom_range(0, 1000);
        return make_tick($urandom_range(0, 11) == 0, $urandom_range(0, 3) == 0, moisture);
    endfunction

    // Random register setting with short runs and intervals
    function automatic t_cfg random_cfg();
        int low;
        low = $urandom_range(100, 600);
        return make_cfg(low, $urandom_range(low, 1000), $urandom_range(1, 24),
                        $urandom_range(1, 16), $urandom_range(1, 6));
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_tick(t_in_item item);
        int gap;
        gap = send_gaps_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        tracker.note_tick(item);
    endtask

    // Drop valid and wait until every result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        tracker.set_register(idx, val);
    endtask

    // Write all five registers back to back; block must be idle
    task automatic load_config(t_cfg c);
        put_reg(CFG_LOW_LIMIT,    CFG_DATA_W'(c.low_moisture_limit));
        put_reg(CFG_HIGH_LIMIT,   CFG_DATA_W'(c.high_moisture_limit));
        put_reg(CFG_AUTO_RUN,     c.auto_run_seconds);
        put_reg(CFG_MANUAL_RUN,   c.manual_run_seconds);
        put_reg(CFG_SAMPLE_EVERY, c.sample_every_seconds);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int count);
        repeat (count) send_tick(random_tick());
        drain();
    endtask

    initial begin
        tracker     = new();
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset settings: auto start/stop, manual entry while
        // pumping, manual run, leaving manual while pumping, overrange sample
        repeat (4) send_tick(make_tick(0, 0, 1000));
        send_tick(make_tick(0, 0, 1000));
        repeat (5) send_tick(make_tick(0, 0, 0));
        send_tick(make_tick(1, 0, 0));
        send_tick(make_tick(0, 1, 512));
        send_tick(make_tick(0, 1, 1023));
        send_tick(make_tick(1, 0, 1023));
        send_tick(make_tick(0, 0, 1023));
        send_tick(make_tick(1, 1, 600));
        send_tick(make_tick(0, 0, 600));
        send_tick(make_tick(1, 0, 600));
        drain();

        // Directed, zero interval and zero run lengths at top limits
        load_config(make_cfg(1000, 1000, 0, 0, 0));
        send_tick(make_tick(0, 0, 999));
        send_tick(make_tick(0, 0, 1023));
        send_tick(make_tick(1, 1, 0));
        send_tick(make_tick(0, 1, 1000));
        send_tick(make_tick(1, 0, 1000));
        drain();

        // Inverted limits, shortest runs and interval
        send_gaps_on   = 1'b1;
        recv_stalls_on = 1'b1;
        load_config(make_cfg(1000, 0, 1, 1, 1));
        random_phase(60);

        // Longest runs and interval, widest window
        send_gaps_on   = 1'b0;
        recv_stalls_on = 1'b0;
        load_config(make_cfg(0, 1000, 4095, 4095, 4095));
        random_phase(20);

        // Long receiver hold-off with the sender at full rate
        load_config(random_cfg());
        hold_off_req = 1'b1;
        random_phase(64);

        // Random settings with random idling on each side
        repeat (4) begin
            send_gaps_on   = 1'($urandom_range(0, 1));
            recv_stalls_on = 1'($urandom_range(0, 1));
            load_config(random_cfg());
            random_phase(64);
        end

        if (tracker.fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/wpmc_pkg.sv
rtl/wpmc_cfg_regs.sv
rtl/wpmc_core.sv
rtl/watering_pump_mode_controller_unit.sv
dv/tb_top.sv
